// ===== rtl/core/anbs_pkg.sv =====
package anbs_pkg;

	// result kinds on the output channel
	localparam logic [1:0] RK_BYTE  = 2'd0;
	localparam logic [1:0] RK_EMPTY = 2'd1;
	localparam logic [1:0] RK_END   = 2'd2;

	// input kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOS  = 1'b1;

	// what closes a command after its payload beats
	localparam logic [1:0] TAIL_NONE  = 2'd0;
	localparam logic [1:0] TAIL_EMPTY = 2'd1;
	localparam logic [1:0] TAIL_END   = 2'd2;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	localparam logic [1:0] ZERO_RUN_MAX = 2'd3;
	localparam logic [1:0] ZERO_RUN_SC  = 2'd2;

	localparam int QUEUE_DEPTH = 4;

	// one command: optional held byte, then zeros, then an optional tail beat
	typedef struct packed {
		logic       hold_en;
		logic [7:0] hold_byte;
		logic [1:0] zeros;
		logic       mark_last;
		logic [1:0] tail;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ===== rtl/core/anbs_if.sv =====
interface anbs_byte_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface anbs_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [7:0] unit_byte;
	logic       unit_last;

	modport source (output valid, output result_kind, output unit_byte, output unit_last,
		input ready);
	modport sink (input valid, input result_kind, input unit_byte, input unit_last,
		output ready);
endinterface

// ===== rtl/core/annexb_nal_unit_splitter.sv =====
// Annex B NAL unit splitter: takes an H.264 Annex B byte stream one beat per byte on
// stream and gives the payload bytes of each NAL unit on units, with start codes
// (00 00 01 and 00 00 00 01) removed and unit_last set on the final byte of each unit.
// Bytes before the first start code are dropped; two start codes back to back give one
// empty-unit beat; an end-of-stream beat on stream flushes the open unit and is followed
// by an end beat, after which the block hunts for a start code again. The front end
// parses one input beat per cycle whenever the command queue has room. One input beat
// can expand into up to five output beats (held byte, three pending zeros, end), and the
// back end issues one output beat per cycle while the receiver is ready, so the sustained
// rate is one byte per cycle on ordinary video data; the QUEUE_DEPTH-entry command queue
// between the two halves absorbs the short bursts after runs of zeros and at end of stream.
module annexb_nal_unit_splitter #(
	parameter int QUEUE_DEPTH = anbs_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	anbs_byte_if.sink     stream,
	anbs_result_if.source units
);

	// front to queue
	logic             q_push;
	anbs_pkg::cmd_t   q_wr_cmd;
	// queue to back
	anbs_pkg::cmd_t   q_head;
	anbs_pkg::qstat_t q_stat;
	logic             q_pop;
	logic             back_fire;

	// parses bytes, tracks start codes and the held byte, emits at most one command per accepted beat
	anbs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.qstat  (q_stat),
		.push   (q_push),
		.cmd    (q_wr_cmd)
	);

	// short command queue so either side can stall independently
	anbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (q_wr_cmd),
		.pop    (q_pop),
		.head   (q_head),
		.qstat  (q_stat)
	);

	// expands each command into output beats through a registered output stage
	anbs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.qstat  (q_stat),
		.pop    (q_pop),
		.fire   (back_fire),
		.units  (units)
	);

	// front only pushes on an accepted beat, and it is only ready while there is room
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_stat.full)
		else $error("command pushed into a full queue");

	// back end never issues a beat from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) back_fire |-> !q_stat.empty)
		else $error("output beat issued with no command queued");

	// empty and end beats carry zero payload and no last flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(units.valid && (units.result_kind != anbs_pkg::RK_BYTE))
		|-> (units.unit_byte == anbs_pkg::BYTE_ZERO) && !units.unit_last)
		else $error("non-byte result with payload or last set");

	// result kind is always one of byte, empty, end
	assert property (@(posedge clk) disable iff (!arst_n)
		units.valid |-> (units.result_kind == anbs_pkg::RK_BYTE)
			|| (units.result_kind == anbs_pkg::RK_EMPTY)
			|| (units.result_kind == anbs_pkg::RK_END))
		else $error("illegal result kind");

endmodule

// ===== rtl/core/anbs_front.sv =====
module anbs_front (
	input  logic                clk,
	input  logic                arst_n,
	anbs_byte_if.sink           stream,
	input  anbs_pkg::qstat_t    qstat,
	output logic                push,
	output anbs_pkg::cmd_t      cmd
);

	logic       inside_q;
	logic [1:0] zero_run_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;

	logic       inside_d;
	logic [1:0] zero_run_d;
	logic       held_valid_d;
	logic [7:0] held_byte_d;

	logic fire;
	logic is_zero;
	logic is_sc;

	assign stream.ready = !qstat.full;
	assign fire         = stream.valid && stream.ready;
	assign is_zero      = (stream.data_byte == anbs_pkg::BYTE_ZERO);
	assign is_sc        = (stream.data_byte == anbs_pkg::BYTE_ONE)
		&& (zero_run_q >= anbs_pkg::ZERO_RUN_SC);

	always_comb begin
		inside_d     = inside_q;
		zero_run_d   = zero_run_q;
		held_valid_d = held_valid_q;
		held_byte_d  = held_byte_q;
		push         = 1'b0;
		cmd.hold_en   = held_valid_q;
		cmd.hold_byte = held_byte_q;
		cmd.zeros     = 2'd0;
		cmd.mark_last = 1'b0;
		cmd.tail      = anbs_pkg::TAIL_NONE;

		if (stream.kind == anbs_pkg::KIND_EOS) begin
			// flush whatever is pending, then the end beat
			push          = fire;
			cmd.hold_en   = inside_q && held_valid_q;
			cmd.zeros     = inside_q ? zero_run_q : 2'd0;
			cmd.mark_last = 1'b1;
			cmd.tail      = anbs_pkg::TAIL_END;
			inside_d      = 1'b0;
			zero_run_d    = 2'd0;
			held_valid_d  = 1'b0;
			held_byte_d   = anbs_pkg::BYTE_ZERO;
		end else if (!inside_q) begin
			// hunting for the first start code
			if (is_zero) begin
				if (zero_run_q != anbs_pkg::ZERO_RUN_MAX) begin
					zero_run_d = zero_run_q + 2'd1;
				end
			end else if (is_sc) begin
				inside_d   = 1'b1;
				zero_run_d = 2'd0;
			end else begin
				zero_run_d = 2'd0;
			end
		end else if (is_zero) begin
			if (zero_run_q != anbs_pkg::ZERO_RUN_MAX) begin
				zero_run_d = zero_run_q + 2'd1;
			end else begin
				// oldest pending zero turns into payload
				push         = fire && held_valid_q;
				held_valid_d = 1'b1;
				held_byte_d  = anbs_pkg::BYTE_ZERO;
			end
		end else if (is_sc) begin
			push          = fire;
			cmd.mark_last = 1'b1;
			cmd.tail      = held_valid_q ? anbs_pkg::TAIL_NONE : anbs_pkg::TAIL_EMPTY;
			zero_run_d    = 2'd0;
			held_valid_d  = 1'b0;
			held_byte_d   = anbs_pkg::BYTE_ZERO;
		end else begin
			push         = fire && (held_valid_q || (zero_run_q != 2'd0));
			cmd.zeros    = zero_run_q;
			zero_run_d   = 2'd0;
			held_valid_d = 1'b1;
			held_byte_d  = stream.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q     <= 1'b0;
			zero_run_q   <= 2'd0;
			held_valid_q <= 1'b0;
			held_byte_q  <= anbs_pkg::BYTE_ZERO;
		end else if (fire) begin
			inside_q     <= inside_d;
			zero_run_q   <= zero_run_d;
			held_valid_q <= held_valid_d;
			held_byte_q  <= held_byte_d;
		end
	end

endmodule

// ===== rtl/core/anbs_queue.sv =====
module anbs_queue #(
	parameter int DEPTH = anbs_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  anbs_pkg::cmd_t   wr_cmd,
	input  logic             pop,
	output anbs_pkg::cmd_t   head,
	output anbs_pkg::qstat_t qstat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	anbs_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	logic do_push;
	logic do_pop;

	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/anbs_back.sv =====
module anbs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  anbs_pkg::cmd_t   head,
	input  anbs_pkg::qstat_t qstat,
	output logic             pop,
	output logic             fire,
	anbs_result_if.source    units
);

	logic       held_done_q;
	logic [1:0] zeros_done_q;

	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic       sel_held;
	logic       sel_zero;
	logic [1:0] zeros_next;
	logic       zero_final;
	logic       is_final;
	logic       load;
	logic [1:0] beat_kind;
	logic [7:0] beat_byte;
	logic       beat_last;

	assign units.valid       = out_valid_q;
	assign units.result_kind = out_kind_q;
	assign units.unit_byte   = out_byte_q;
	assign units.unit_last   = out_last_q;

	always_comb begin
		sel_held   = head.hold_en && !held_done_q;
		sel_zero   = !sel_held && (zeros_done_q != head.zeros);
		zeros_next = zeros_done_q + 2'd1;
		zero_final = (zeros_next == head.zeros);
		if (sel_held) begin
			beat_kind = anbs_pkg::RK_BYTE;
			beat_byte = head.hold_byte;
			beat_last = head.mark_last && (head.zeros == 2'd0);
			is_final  = (head.zeros == 2'd0) && (head.tail == anbs_pkg::TAIL_NONE);
		end else if (sel_zero) begin
			beat_kind = anbs_pkg::RK_BYTE;
			beat_byte = anbs_pkg::BYTE_ZERO;
			beat_last = head.mark_last && zero_final;
			is_final  = zero_final && (head.tail == anbs_pkg::TAIL_NONE);
		end else begin
			beat_kind = (head.tail == anbs_pkg::TAIL_END) ? anbs_pkg::RK_END
				: anbs_pkg::RK_EMPTY;
			beat_byte = anbs_pkg::BYTE_ZERO;
			beat_last = 1'b0;
			is_final  = 1'b1;
		end
	end

	assign load = !out_valid_q || units.ready;
	assign fire = load && !qstat.empty;
	assign pop  = fire && is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_done_q  <= 1'b0;
			zeros_done_q <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= fire;
			end
			if (pop) begin
				held_done_q  <= 1'b0;
				zeros_done_q <= 2'd0;
			end else if (fire) begin
				if (sel_held) begin
					held_done_q <= 1'b1;
				end else if (sel_zero) begin
					zeros_done_q <= zeros_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_kind_q <= beat_kind;
			out_byte_q <= beat_byte;
			out_last_q <= beat_last;
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	// one beat offered on the byte stream
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} stream_beat_t;

	// one beat awaited on the unit channel
	typedef struct packed {
		logic [1:0] rkind;
		logic [7:0] ubyte;
		logic       ulast;
	} unit_beat_t;

	localparam int HOLD_CYCLES   = 64;   // long receiver hold-off, fills the command queue
	localparam int QUIET_LIMIT   = 2000; // cycles without any beat before giving up
	localparam int TAIL_CYCLES   = 20;   // settle time after the last awaited beat
	localparam int RANDOM_PER_PH = 105;
	localparam int NUM_PHASES    = 4;
	localparam int MAX_REPORTS   = 10;

	logic clk;
	logic arst_n     = 1'b0;
	logic send_valid = 1'b0;
	logic send_kind  = anbs_pkg::KIND_BYTE;
	logic [7:0] send_data = anbs_pkg::BYTE_ZERO;
	logic recv_ready = 1'b0;

	anbs_byte_if   stream_if ();
	anbs_result_if units_if ();

	assign stream_if.valid     = send_valid;
	assign stream_if.kind      = send_kind;
	assign stream_if.data_byte = send_data;
	assign units_if.ready      = recv_ready;

	annexb_nal_unit_splitter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.units  (units_if)
	);

	stream_beat_t pending_items[$];
	unit_beat_t   due_unit_beats[$];
	stream_beat_t next_item;

	// idling knobs, set by the sequencer at falling edges only; holds_served and hold_left are tracked by the monitor
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;

	int err_count = 0;
	int quiet_cycles = 0;

	int idle_by_phase[NUM_PHASES]  = '{0, 78, 0, 30};
	int stall_by_phase[NUM_PHASES] = '{0, 0, 78, 30};

	// splitter state as the predictor sees it
	logic       in_unit = 1'b0;
	logic [1:0] zeros_pending = 2'd0;
	logic       hold_valid = 1'b0;
	logic [7:0] hold_byte = anbs_pkg::BYTE_ZERO;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic await_unit_beat(input logic [1:0] rk, input logic [7:0] b, input logic l);
		unit_beat_t w;
		w.rkind = rk;
		w.ubyte = b;
		w.ulast = l;
		due_unit_beats.insert(due_unit_beats.size(), w);
	endtask

	// advance the splitter state by one accepted stream beat, queue the unit beats it yields
	task automatic split_nal_byte(input logic kind, input logic [7:0] b);
		int total;
		int n;
		int i;
		if (kind == anbs_pkg::KIND_EOS) begin
			// flush held byte then pending zeros, last on the final one
			if (in_unit) begin
				total = int'(hold_valid) + int'(zeros_pending);
				n = 0;
				if (hold_valid) begin
					n++;
					await_unit_beat(anbs_pkg::RK_BYTE, hold_byte, n == total);
				end
				for (i = 0; i < int'(zeros_pending); i++) begin
					n++;
					await_unit_beat(anbs_pkg::RK_BYTE, anbs_pkg::BYTE_ZERO, n == total);
				end
			end
			await_unit_beat(anbs_pkg::RK_END, anbs_pkg::BYTE_ZERO, 1'b0);
			in_unit = 1'b0;
			zeros_pending = 2'd0;
			hold_valid = 1'b0;
			hold_byte = anbs_pkg::BYTE_ZERO;
		end else if (!in_unit) begin
			// hunting for the first start code, nothing comes out
			if (b == anbs_pkg::BYTE_ZERO) begin
				if (zeros_pending != anbs_pkg::ZERO_RUN_MAX)
					zeros_pending++;
			end else if (b == anbs_pkg::BYTE_ONE && zeros_pending >= anbs_pkg::ZERO_RUN_SC) begin
				in_unit = 1'b1;
				zeros_pending = 2'd0;
			end else begin
				zeros_pending = 2'd0;
			end
		end else if (b == anbs_pkg::BYTE_ZERO) begin
			if (zeros_pending != anbs_pkg::ZERO_RUN_MAX) begin
				zeros_pending++;
			end else begin
				// fourth zero: the oldest pending zero turns into payload
				if (hold_valid)
					await_unit_beat(anbs_pkg::RK_BYTE, hold_byte, 1'b0);
				hold_byte = anbs_pkg::BYTE_ZERO;
				hold_valid = 1'b1;
			end
		end else if (b == anbs_pkg::BYTE_ONE && zeros_pending >= anbs_pkg::ZERO_RUN_SC) begin
			// start code closes the unit, or marks an empty one
			if (hold_valid)
				await_unit_beat(anbs_pkg::RK_BYTE, hold_byte, 1'b1);
			else
				await_unit_beat(anbs_pkg::RK_EMPTY, anbs_pkg::BYTE_ZERO, 1'b0);
			zeros_pending = 2'd0;
			hold_valid = 1'b0;
			hold_byte = anbs_pkg::BYTE_ZERO;
		end else begin
			// ordinary payload, pending zeros were data after all
			if (hold_valid)
				await_unit_beat(anbs_pkg::RK_BYTE, hold_byte, 1'b0);
			for (i = 0; i < int'(zeros_pending); i++)
				await_unit_beat(anbs_pkg::RK_BYTE, anbs_pkg::BYTE_ZERO, 1'b0);
			zeros_pending = 2'd0;
			hold_byte = b;
			hold_valid = 1'b1;
		end
	endtask

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_unit_beat();
		unit_beat_t want;
		if (due_unit_beats.size() == 0) begin
			report_error($sformatf("unit beat with none awaited: kind %0d byte %02h last %0d",
				units_if.result_kind, units_if.unit_byte, units_if.unit_last));
		end else begin
			want = due_unit_beats.pop_front();
			if (units_if.result_kind !== want.rkind || units_if.unit_byte !== want.ubyte ||
				units_if.unit_last !== want.ulast)
				report_error($sformatf(
					"unit beat mismatch: want kind %0d byte %02h last %0d, got %0d %02h %0d",
					want.rkind, want.ubyte, want.ulast,
					units_if.result_kind, units_if.unit_byte, units_if.unit_last));
		end
	endtask

	// driver: predicts on acceptance, then offers the next pending beat or idles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_valid <= 1'b0;
			send_kind <= anbs_pkg::KIND_BYTE;
			send_data <= anbs_pkg::BYTE_ZERO;
		end else begin
			if (send_valid && stream_if.ready)
				split_nal_byte(send_kind, send_data);
			if (!send_valid || stream_if.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					send_valid <= 1'b1;
					send_kind <= next_item.kind;
					send_data <= next_item.data;
				end else begin
					send_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted unit beat, drives ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_ready <= 1'b0;
		end else begin
			if (units_if.valid && recv_ready)
				check_unit_beat();
			if (holds_served != hold_requests) begin
				// long hold-off, the sender keeps offering meanwhile
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
				recv_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left = hold_left - 1;
				recv_ready <= 1'b0;
			end else begin
				recv_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((send_valid && stream_if.ready) || (units_if.valid && recv_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no beat for %0d cycles", QUIET_LIMIT);
				$display("testbench failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		stream_beat_t it;
		it.kind = anbs_pkg::KIND_BYTE;
		it.data = b;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic queue_eos();
		stream_beat_t it;
		it.kind = anbs_pkg::KIND_EOS;
		it.data = 8'($urandom_range(255)); // don't care at end of stream
		pending_items.insert(pending_items.size(), it);
	endtask

	// payload biased toward the bytes that matter to start code detection
	function automatic logic [7:0] payload_byte();
		logic [7:0] v;
		case ($urandom_range(7))
			0: v = anbs_pkg::BYTE_ZERO;
			1: v = anbs_pkg::BYTE_ONE;
			2: v = 8'h03;
			default: v = 8'($urandom_range(255));
		endcase
		return v;
	endfunction

	// mostly well-formed units with random content, some noise and broken start codes
	task automatic queue_random_stream(input int count);
		int base;
		int r;
		int len;
		int i;
		base = pending_items.size();
		while (pending_items.size() - base < count) begin
			r = $urandom_range(99);
			if (r < 5) begin
				queue_byte(8'($urandom_range(255)));
			end else if (r < 9) begin
				queue_eos();
			end else if (r < 15) begin
				// broken start code: one zero then 01, or two zeros then not 01
				queue_byte(anbs_pkg::BYTE_ZERO);
				if ($urandom_range(1)) begin
					queue_byte(anbs_pkg::BYTE_ZERO);
					queue_byte(8'($urandom_range(2, 255)));
				end else begin
					queue_byte(anbs_pkg::BYTE_ONE);
				end
			end else begin
				// start code, three or four bytes, sometimes with extra zeros ahead
				repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0)
					queue_byte(anbs_pkg::BYTE_ZERO);
				queue_byte(anbs_pkg::BYTE_ZERO);
				queue_byte(anbs_pkg::BYTE_ZERO);
				if ($urandom_range(1))
					queue_byte(anbs_pkg::BYTE_ZERO);
				queue_byte(anbs_pkg::BYTE_ONE);
				len = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(8);
				for (i = 0; i < len; i++) begin
					if ($urandom_range(5) == 0)
						repeat ($urandom_range(1, 5)) queue_byte(anbs_pkg::BYTE_ZERO);
					else
						queue_byte(payload_byte());
				end
			end
		end
	endtask

	// sender pause: nothing left to offer and every awaited beat has come
	task automatic wait_drained();
		while (pending_items.size() != 0 || send_valid || due_unit_beats.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int ph;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: end before any start code
		queue_eos();
		// junk before the first start code, including one zero then 01
		queue_byte(8'hab); queue_byte(anbs_pkg::BYTE_ZERO); queue_byte(anbs_pkg::BYTE_ONE);
		// three byte start code, then end with nothing pending
		queue_byte(anbs_pkg::BYTE_ZERO); queue_byte(anbs_pkg::BYTE_ZERO);
		queue_byte(anbs_pkg::BYTE_ONE);
		queue_eos();
		queue_byte(anbs_pkg::BYTE_ZERO); queue_byte(anbs_pkg::BYTE_ZERO);
		queue_byte(anbs_pkg::BYTE_ONE);
		// 01 with no zero ahead is payload
		queue_byte(8'hff); queue_byte(anbs_pkg::BYTE_ONE);
		// five zeros: fourth and fifth push the oldest zero out as payload
		repeat (5) queue_byte(anbs_pkg::BYTE_ZERO);
		queue_byte(8'h7f);
		// four byte start code closes the unit on 7f
		queue_byte(anbs_pkg::BYTE_ZERO); queue_byte(anbs_pkg::BYTE_ZERO);
		queue_byte(anbs_pkg::BYTE_ZERO); queue_byte(anbs_pkg::BYTE_ONE);
		// back to back start code gives an empty unit
		queue_byte(anbs_pkg::BYTE_ZERO); queue_byte(anbs_pkg::BYTE_ZERO);
		queue_byte(anbs_pkg::BYTE_ONE);
		// end with a trailing zero pending
		queue_byte(8'h80); queue_byte(anbs_pkg::BYTE_ZERO); queue_eos();
		wait_drained();

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct = idle_by_phase[ph];
			recv_stall_pct = stall_by_phase[ph];
			if (ph == 0 || ph == 3)
				hold_requests++;
			queue_random_stream(RANDOM_PER_PH);
			if (ph == NUM_PHASES - 1)
				queue_eos();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_unit_beats.size() != 0) begin
			err_count += due_unit_beats.size();
			$display("%0d unit beats never arrived", due_unit_beats.size());
		end
		if (err_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
